FILE: rtl/rotation_matrix_to_euler_core_defines.svh
// ---------------------------------------------------------------------------
// Rotation matrix to Euler angles: assertion macros
// Concurrent assertion helpers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_EULER_CORE_DEFINES_SVH
`define ROTATION_MATRIX_TO_EULER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge out of reset.
`define RME_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define RME_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define RME_ASSERT_IMP(label, clk, rst, ante, cons)
`define RME_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/rme_pkg.sv
// ---------------------------------------------------------------------------
// Rotation matrix to Euler angles: shared package
// Widths, pipeline depths, angle constants and the arctangent table.
// ---------------------------------------------------------------------------
`default_nettype none

package rme_pkg;

   // Matrix entry width and number of CORDIC iterations.
   localparam int DATA_W       = 16;
   localparam int CORDIC_STEPS = 16;

   // Square root datapath: sum of squares and its root.
   localparam int SQ_W        = 2 * DATA_W;
   localparam int ROOT_W      = DATA_W;
   localparam int SQRT_ITERS  = DATA_W;
   localparam int SQRT_PER_ST = 2;
   localparam int SQRT_STAGES = (SQRT_ITERS + SQRT_PER_ST - 1) / SQRT_PER_ST;
   // Square register, sum register, then the root stages.
   localparam int SQ_LAT      = SQRT_STAGES + 2;

   // CORDIC datapath.
   localparam int VIN_W        = DATA_W + 2;
   localparam int VEC_SHIFT    = 8;
   localparam int CW           = DATA_W + VEC_SHIFT + 3;
   localparam int ZW           = 20;
   localparam int ITER_PER_ST  = 2;
   localparam int CORDIC_STAGES = (CORDIC_STEPS + ITER_PER_ST - 1) / ITER_PER_ST;
   // Pre-rotation register, iteration stages, rounding register.
   localparam int CORDIC_LAT   = CORDIC_STAGES + 2;

   // Whole pipeline: square root part, operand select register, CORDIC.
   localparam int PIPE_LAT = SQ_LAT + 1 + CORDIC_LAT;

   // Field widths.
   localparam int ANG_W   = 16;
   localparam int PITCH_W = 15;
   localparam int LIMIT_W = 15;
   localparam int CMP_W   = (ROOT_W > LIMIT_W) ? ROOT_W : LIMIT_W;
   localparam int N_ENTRIES   = 7;
   localparam int REQ_TDATA_W = ((N_ENTRIES * DATA_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W = 2 * ANG_W + PITCH_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   // Angle constants: Q.16 accumulator, Q3.13 results.
   localparam logic signed [ZW-1:0] HALF_PI_Q16  = ZW'(102944);
   localparam logic signed [ZW-1:0] PI_Q313      = ZW'(25736);
   localparam logic signed [ZW-1:0] HALF_PI_Q313 = ZW'(12868);
   localparam logic signed [ZW-1:0] ROUND_ADD    = ZW'(4);
   localparam int ROUND_SHIFT = 3;
   localparam int ANG_TAB_LEN = 24;

   // Reset value of the singularity limit.
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1);

   // The seven matrix entries used, as they travel down the pipeline.
   typedef struct packed {
      logic signed [DATA_W-1:0] r00;
      logic signed [DATA_W-1:0] r10;
      logic signed [DATA_W-1:0] r11;
      logic signed [DATA_W-1:0] r12;
      logic signed [DATA_W-1:0] r20;
      logic signed [DATA_W-1:0] r21;
      logic signed [DATA_W-1:0] r22;
   } mat_type;

   // atan(2^-i) in Q.16 radians, rounded to nearest.
   function automatic logic signed [ZW-1:0] ang_tab(input int unsigned idx);
      logic signed [ZW-1:0] val;
      case (idx)
         0:       val = ZW'(51472);
         1:       val = ZW'(30386);
         2:       val = ZW'(16055);
         3:       val = ZW'(8150);
         4:       val = ZW'(4091);
         5:       val = ZW'(2047);
         6:       val = ZW'(1024);
         7:       val = ZW'(512);
         8:       val = ZW'(256);
         9:       val = ZW'(128);
         10:      val = ZW'(64);
         11:      val = ZW'(32);
         12:      val = ZW'(16);
         13:      val = ZW'(8);
         14:      val = ZW'(4);
         15:      val = ZW'(2);
         16:      val = ZW'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/rme_sqrt.sv
// ---------------------------------------------------------------------------
// Rotation matrix to Euler angles: pipelined sy
// Computes floor(sqrt(r00^2 + r10^2)), two root bits per stage, and
// carries the matrix entries alongside.
// ---------------------------------------------------------------------------
`default_nettype none

module rme_sqrt (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire rme_pkg::mat_type             mat_in,
   output      rme_pkg::mat_type             mat_out,
   output      logic [rme_pkg::ROOT_W-1:0]   sy_out
);

   localparam int DW = rme_pkg::DATA_W;
   localparam int SW = rme_pkg::SQ_W;
   localparam int NS = rme_pkg::SQRT_STAGES;

   logic [DW-1:0] abs_a;
   logic [DW-1:0] abs_b;
   logic [SW-1:0] sq_a_ff;
   logic [SW-1:0] sq_b_ff;

   logic [SW-1:0] n_ff    [NS+1];
   logic [SW-1:0] root_ff [NS+1];

   rme_pkg::mat_type mat_ff [rme_pkg::SQ_LAT];

   // Magnitudes and squares of the two column entries.
   assign abs_a = mat_in.r00[DW-1] ? DW'(-mat_in.r00) : DW'(mat_in.r00);
   assign abs_b = mat_in.r10[DW-1] ? DW'(-mat_in.r10) : DW'(mat_in.r10);

   always_ff @(posedge clock) begin
      if (en) begin
         sq_a_ff <= SW'(abs_a) * SW'(abs_a);
         sq_b_ff <= SW'(abs_b) * SW'(abs_b);
      end
   end

   // Sum of squares; the root starts at zero.
   always_ff @(posedge clock) begin
      if (en) begin
         n_ff[0]    <= sq_a_ff + sq_b_ff;
         root_ff[0] <= '0;
      end
   end

   // Digit-by-digit root, two result bits per stage.
   for (genvar s = 0; s < NS; s++) begin : g_root
      logic [SW-1:0] n_in;
      logic [SW-1:0] root_in;
      logic [SW-1:0] bit_v;
      logic [SW:0]   trial;

      always_comb begin
         n_in    = n_ff[s];
         root_in = root_ff[s];
         bit_v   = '0;
         trial   = '0;
         for (int j = 0; j < rme_pkg::SQRT_PER_ST; j++) begin
            if (s * rme_pkg::SQRT_PER_ST + j < rme_pkg::SQRT_ITERS) begin
               bit_v = SW'(1) << (SW - 2 - 2 * (s * rme_pkg::SQRT_PER_ST + j));
               trial = {1'b0, root_in} + {1'b0, bit_v};
               if ({1'b0, n_in} >= trial) begin
                  n_in    = n_in - trial[SW-1:0];
                  root_in = (root_in >> 1) + bit_v;
               end else begin
                  root_in = root_in >> 1;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[s+1]    <= n_in;
            root_ff[s+1] <= root_in;
         end
      end
   end

   assign sy_out = root_ff[NS][rme_pkg::ROOT_W-1:0];

   // Matrix entries follow the root through the same number of registers.
   always_ff @(posedge clock) begin
      if (en) begin
         mat_ff[0] <= mat_in;
         for (int k = 1; k < rme_pkg::SQ_LAT; k++) begin
            mat_ff[k] <= mat_ff[k-1];
         end
      end
   end

   assign mat_out = mat_ff[rme_pkg::SQ_LAT-1];

endmodule

`default_nettype wire

FILE: rtl/rme_cordic.sv
// ---------------------------------------------------------------------------
// Rotation matrix to Euler angles: CORDIC vectoring pipeline
// atan2(y, x) in Q3.13 radians, two iterations per stage, clamped to pi
// or to pi/2.
// ---------------------------------------------------------------------------
`default_nettype none

module rme_cordic (
   input  wire logic                              clock,
   input  wire logic                              en,
   input  wire logic                              half_range,
   input  wire logic signed [rme_pkg::VIN_W-1:0]  x_in,
   input  wire logic signed [rme_pkg::VIN_W-1:0]  y_in,
   output      logic signed [rme_pkg::ANG_W-1:0]  angle_out
);

   localparam int CW = rme_pkg::CW;
   localparam int ZW = rme_pkg::ZW;
   localparam int NS = rme_pkg::CORDIC_STAGES;

   logic signed [CW-1:0] x_ff [NS+1];
   logic signed [CW-1:0] y_ff [NS+1];
   logic signed [ZW-1:0] z_ff [NS+1];
   logic                 zero_ff  [NS+1];
   logic                 half_ff  [NS+1];

   logic signed [CW-1:0] xs;
   logic signed [CW-1:0] ys;
   logic signed [CW-1:0] xp;
   logic signed [CW-1:0] yp;
   logic signed [ZW-1:0] zp;

   logic signed [ZW-1:0] zr;
   logic signed [ZW-1:0] lim;
   logic signed [ZW-1:0] ang_c;
   logic signed [rme_pkg::ANG_W-1:0] angle_ff;

   // Scale the operands and turn the left half plane by a quarter turn.
   always_comb begin
      xs = CW'(x_in) <<< rme_pkg::VEC_SHIFT;
      ys = CW'(y_in) <<< rme_pkg::VEC_SHIFT;
      xp = xs;
      yp = ys;
      zp = '0;
      if (xs < 0) begin
         if (ys >= 0) begin
            xp = ys;
            yp = -xs;
            zp = rme_pkg::HALF_PI_Q16;
         end else begin
            xp = -ys;
            yp = xs;
            zp = -rme_pkg::HALF_PI_Q16;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= xp;
         y_ff[0]    <= yp;
         z_ff[0]    <= zp;
         zero_ff[0] <= (x_in == '0) && (y_in == '0);
         half_ff[0] <= half_range;
      end
   end

   // Vectoring iterations: drive y towards zero, accumulate the angle.
   for (genvar s = 0; s < NS; s++) begin : g_iter
      logic signed [CW-1:0] xv;
      logic signed [CW-1:0] yv;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [ZW-1:0] zv;

      always_comb begin
         xv = x_ff[s];
         yv = y_ff[s];
         zv = z_ff[s];
         dx = '0;
         dy = '0;
         for (int j = 0; j < rme_pkg::ITER_PER_ST; j++) begin
            if (s * rme_pkg::ITER_PER_ST + j < rme_pkg::CORDIC_STEPS) begin
               dx = yv >>> (s * rme_pkg::ITER_PER_ST + j);
               dy = xv >>> (s * rme_pkg::ITER_PER_ST + j);
               if (!yv[CW-1]) begin
                  xv = xv + dx;
                  yv = yv - dy;
                  zv = zv + rme_pkg::ang_tab(s * rme_pkg::ITER_PER_ST + j);
               end else begin
                  xv = xv - dx;
                  yv = yv + dy;
                  zv = zv - rme_pkg::ang_tab(s * rme_pkg::ITER_PER_ST + j);
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[s+1]    <= xv;
            y_ff[s+1]    <= yv;
            z_ff[s+1]    <= zv;
            zero_ff[s+1] <= zero_ff[s];
            half_ff[s+1] <= half_ff[s];
         end
      end
   end

   // Round Q.16 to Q3.13 (floor of z / 8 after adding a half) and clamp.
   always_comb begin
      zr    = (z_ff[NS] + rme_pkg::ROUND_ADD) >>> rme_pkg::ROUND_SHIFT;
      lim   = half_ff[NS] ? rme_pkg::HALF_PI_Q313 : rme_pkg::PI_Q313;
      ang_c = zr;
      if (zr > lim) begin
         ang_c = lim;
      end else if (zr < -lim) begin
         ang_c = -lim;
      end
      if (zero_ff[NS]) begin
         ang_c = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= ang_c[rme_pkg::ANG_W-1:0];
      end
   end

   assign angle_out = angle_ff;

endmodule

`default_nettype wire

FILE: rtl/rotation_matrix_to_euler_core.sv
// ---------------------------------------------------------------------------
// Rotation matrix to Euler angles (XYZ), pipelined core
// Converts seven Q2.14 rotation matrix entries into roll, pitch and yaw in
// Q3.13 radians, with gimbal-lock detection against a programmable limit.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Beat contents
//   -------  ---------  ----------------------------------------------------
//   req      in         r00, r10, r11, r12, r20, r21, r22 (16 bits each)
//   rsp      out        roll, pitch, yaw; singular flag on tuser
//   csr      in         singular_limit (15 bits), write only
//
// One beat enters per cycle while rsp is not stalled; each beat passes through
// the SQ_LAT + 1 + CORDIC_LAT pipeline registers, whose depth is set by the eight
// two-bit square root stages and the eight two-iteration CORDIC stages.
// Reset clears the valid bits and sets singular_limit to 1.
// When a result waits on rsp the whole pipeline holds and req_tready falls;
// nothing is dropped or repeated.
// ---------------------------------------------------------------------------
`default_nettype none

`include "rotation_matrix_to_euler_core_defines.svh"

module rotation_matrix_to_euler_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // r00, r10, r11, r12, r20, r21, r22 from bit 0 upwards
   input  wire logic [rme_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   // roll, pitch, yaw from bit 0 upwards, zero fill at the top
   output      logic [rme_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // singular
   output      logic                                rsp_tuser,
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic                                csr_wr_en,
   input  wire logic [rme_pkg::LIMIT_W-1:0]         csr_wr_data
);

   localparam int DW   = rme_pkg::DATA_W;
   localparam int VW   = rme_pkg::VIN_W;
   localparam int CL   = rme_pkg::CORDIC_LAT;
   localparam int PL   = rme_pkg::PIPE_LAT;

   logic                        adv;
   logic [PL-1:0]               vld_ff;
   logic [rme_pkg::LIMIT_W-1:0] limit_ff;

   rme_pkg::mat_type            mat_in;
   rme_pkg::mat_type            mat_sq;
   logic [rme_pkg::ROOT_W-1:0]  sy;
   logic                        sing_c;

   logic signed [VW-1:0] pitch_x_ff, pitch_y_ff;
   logic signed [VW-1:0] roll_x_ff, roll_y_ff;
   logic signed [VW-1:0] yaw_x_ff, yaw_y_ff;
   logic [CL:0]          sing_ff;

   logic signed [rme_pkg::ANG_W-1:0] roll_ang;
   logic signed [rme_pkg::ANG_W-1:0] pitch_ang;
   logic signed [rme_pkg::ANG_W-1:0] yaw_ang;

   // The pipeline moves whenever the output register is empty or taken.
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PL-2:0], req_tvalid};
      end
   end

   assign rsp_tvalid = vld_ff[PL-1];

   // Singularity limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= rme_pkg::LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // Unpack the request beat.
   assign mat_in.r00 = req_tdata[0*DW +: DW];
   assign mat_in.r10 = req_tdata[1*DW +: DW];
   assign mat_in.r11 = req_tdata[2*DW +: DW];
   assign mat_in.r12 = req_tdata[3*DW +: DW];
   assign mat_in.r20 = req_tdata[4*DW +: DW];
   assign mat_in.r21 = req_tdata[5*DW +: DW];
   assign mat_in.r22 = req_tdata[6*DW +: DW];

   rme_sqrt u_sqrt (
      .clock   (clock),
      .en      (adv),
      .mat_in  (mat_in),
      .mat_out (mat_sq),
      .sy_out  (sy)
   );

   // Singularity decision and operand selection for the three arctangents.
   assign sing_c = rme_pkg::CMP_W'(sy) < rme_pkg::CMP_W'(limit_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         pitch_x_ff <= $signed({{(VW-rme_pkg::ROOT_W){1'b0}}, sy});
         pitch_y_ff <= -VW'(mat_sq.r20);
         if (sing_c) begin
            roll_x_ff <= VW'(mat_sq.r11);
            roll_y_ff <= -VW'(mat_sq.r12);
            yaw_x_ff  <= '0;
            yaw_y_ff  <= '0;
         end else begin
            roll_x_ff <= VW'(mat_sq.r22);
            roll_y_ff <= VW'(mat_sq.r21);
            yaw_x_ff  <= VW'(mat_sq.r00);
            yaw_y_ff  <= VW'(mat_sq.r10);
         end
         sing_ff <= {sing_ff[CL-1:0], sing_c};
      end
   end

   rme_cordic u_roll (
      .clock      (clock),
      .en         (adv),
      .half_range (1'b0),
      .x_in       (roll_x_ff),
      .y_in       (roll_y_ff),
      .angle_out  (roll_ang)
   );

   rme_cordic u_pitch (
      .clock      (clock),
      .en         (adv),
      .half_range (1'b1),
      .x_in       (pitch_x_ff),
      .y_in       (pitch_y_ff),
      .angle_out  (pitch_ang)
   );

   // A zero vector gives a zero yaw when the matrix is singular.
   rme_cordic u_yaw (
      .clock      (clock),
      .en         (adv),
      .half_range (1'b0),
      .x_in       (yaw_x_ff),
      .y_in       (yaw_y_ff),
      .angle_out  (yaw_ang)
   );

   // Pack the response beat.
   assign rsp_tdata = {{(rme_pkg::RSP_TDATA_W - rme_pkg::RSP_FIELD_W){1'b0}},
                       yaw_ang,
                       pitch_ang[rme_pkg::PITCH_W-1:0],
                       roll_ang};
   assign rsp_tuser = sing_ff[CL];

   // A waiting result freezes the pipeline and closes the input.
   `RME_ASSERT_IMP(a_stall_blocks_input, clock, reset,
                   rsp_tvalid && !rsp_tready, !req_tready)

   // An accepted beat enters the first stage.
   `RME_ASSERT_NXT(a_accept_enters, clock, reset,
                   req_tvalid && req_tready, vld_ff[0])

   // Yaw is zero whenever the singular flag is set.
   `RME_ASSERT_IMP(a_singular_yaw_zero, clock, reset,
                   rsp_tvalid && rsp_tuser, yaw_ang == '0)

   // Pitch stays within plus or minus pi/2.
   `RME_ASSERT_IMP(a_pitch_range, clock, reset, rsp_tvalid,
                   (rme_pkg::ZW'(pitch_ang) <= rme_pkg::HALF_PI_Q313) &&
                   (rme_pkg::ZW'(pitch_ang) >= -rme_pkg::HALF_PI_Q313))

endmodule

`default_nettype wire

FILE: verif/tb_rotation_matrix_to_euler_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Rotation matrix to Euler angles: self-checking testbench
// Streams rotation matrices, gimbal-lock cases and raw bit patterns into the
// core under random source and sink idling, predicts roll, pitch, yaw and the
// singular flag for every accepted beat, and compares each result beat in
// order. The singularity limit is reprogrammed between phases.
// ---------------------------------------------------------------------------

module tb_rotation_matrix_to_euler_core;

   localparam int  PIPE_LAT     = rme_pkg::PIPE_LAT;
   localparam int  ANG_W        = rme_pkg::ANG_W;
   localparam int  PITCH_W      = rme_pkg::PITCH_W;
   localparam int  LIMIT_W      = rme_pkg::LIMIT_W;
   localparam int  REQ_TDATA_W  = rme_pkg::REQ_TDATA_W;
   localparam int  RSP_TDATA_W  = rme_pkg::RSP_TDATA_W;
   localparam int  CORDIC_STEPS = rme_pkg::CORDIC_STEPS;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = rme_pkg::LIMIT_RESET;

   typedef rme_pkg::mat_type mat_type;

   localparam real PI_R        = 3.14159265358979;
   localparam int  CHAN_STALL  = 23;   // idle chance per cycle, in percent
   localparam int  SETTLE_CYC  = 2 * PIPE_LAT + 8;

   // One expected result beat.
   typedef struct {
      logic [ANG_W-1:0]   roll;
      logic [PITCH_W-1:0] pitch;
      logic [ANG_W-1:0]   yaw;
      logic               singular;
   } angle_set_type;

   // Predicts the Euler angles of every accepted matrix and checks the
   // result beats against them in arrival order.
   class euler_checker;
      logic [LIMIT_W-1:0] limit;
      angle_set_type      angles_due[$];
      int                 bad_beats;
      int                 stray_beats;

      // atan(2^-i) in Q.16 radians.
      longint atan_q16[24] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                               256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

      function new();
         limit = LIMIT_RESET;
      endfunction

      function void set_limit(logic [LIMIT_W-1:0] value);
         limit = value;
      endfunction

      // Floor of the square root, built up one bit at a time.
      function longint int_root(longint n);
         longint root;
         longint trial;
         root = 0;
         for (int b = 17; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= n)
               root = trial;
         end
         return root;
      endfunction

      // CORDIC vectoring atan2 giving Q3.13 radians, clamped to +-lim.
      function longint arc_q313(longint y, longint x, longint lim);
         longint z;
         longint t;
         longint dx;
         longint dy;
         if (x == 0 && y == 0)
            return 0;
         z = 0;
         x = x * 256;
         y = y * 256;
         // Left half plane: quarter turn into the right half first.
         if (x < 0) begin
            t = x;
            if (y >= 0) begin
               x = y;
               y = -t;
               z = 102944;
            end else begin
               x = -y;
               y = t;
               z = -102944;
            end
         end
         for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x += dx;
               y -= dy;
               z += atan_q16[i];
            end else begin
               x -= dx;
               y += dy;
               z -= atan_q16[i];
            end
         end
         z = (z + 4) >>> 3;
         if (z > lim)
            z = lim;
         if (z < -lim)
            z = -lim;
         return z;
      endfunction

      // Works out the result of one accepted matrix beat.
      function void note_matrix(mat_type m);
         longint        mag0;
         longint        mag1;
         longint        sy_v;
         angle_set_type exp_set;
         mag0 = longint'(m.r00);
         mag1 = longint'(m.r10);
         if (mag0 < 0)
            mag0 = -mag0;
         if (mag1 < 0)
            mag1 = -mag1;
         sy_v = int_root(mag0 * mag0 + mag1 * mag1);
         exp_set.singular = (sy_v < longint'(limit));
         exp_set.pitch = PITCH_W'(arc_q313(-longint'(m.r20), sy_v, 12868));
         if (!exp_set.singular) begin
            exp_set.roll = ANG_W'(arc_q313(longint'(m.r21), longint'(m.r22), 25736));
            exp_set.yaw  = ANG_W'(arc_q313(longint'(m.r10), longint'(m.r00), 25736));
         end else begin
            exp_set.roll = ANG_W'(arc_q313(-longint'(m.r12), longint'(m.r11), 25736));
            exp_set.yaw  = '0;
         end
         angles_due.push_back(exp_set);
      endfunction

      // Compares one result beat with the oldest expectation.
      function void check_angles(logic [RSP_TDATA_W-1:0] data, logic sing);
         angle_set_type got;
         angle_set_type exp_set;
         got.roll     = data[ANG_W-1:0];
         got.pitch    = data[ANG_W+PITCH_W-1:ANG_W];
         got.yaw      = data[2*ANG_W+PITCH_W-1:ANG_W+PITCH_W];
         got.singular = sing;
         if (angles_due.size() == 0) begin
            stray_beats++;
            if (bad_beats + stray_beats <= 10)
               $display("ERROR: result beat with nothing expected: roll %0d pitch %0d",
                        $signed(got.roll), $signed(got.pitch));
            return;
         end
         exp_set = angles_due.pop_front();
         if (got.roll !== exp_set.roll || got.pitch !== exp_set.pitch ||
             got.yaw !== exp_set.yaw || got.singular !== exp_set.singular) begin
            bad_beats++;
            if (bad_beats + stray_beats <= 10)
               $display("ERROR: expected roll %0d pitch %0d yaw %0d singular %0b, %s%0d %0d %0d %0b",
                        $signed(exp_set.roll), $signed(exp_set.pitch), $signed(exp_set.yaw),
                        exp_set.singular, "got ", $signed(got.roll), $signed(got.pitch),
                        $signed(got.yaw), got.singular);
         end
      endfunction

      function int outstanding();
         return angles_due.size();
      endfunction

      function int failures();
         return bad_beats + stray_beats + angles_due.size();
      endfunction
   endclass

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic                   csr_wr_en   = 1'b0;
   logic [LIMIT_W-1:0]     csr_wr_data = '0;
   logic                   steady      = 1'b0;   // no idling on either side

   euler_checker chk = new();

   always #1 clock = ~clock;

   rotation_matrix_to_euler_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Sink: stalls at random outside the steady stretch.
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= CHAN_STALL);
   end

   // Every result beat is checked at the edge that accepts it.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         chk.check_angles(rsp_tdata, rsp_tuser);
   end

   function automatic mat_type matrix_of(int a00, int a10, int a11, int a12,
                                         int a20, int a21, int a22);
      mat_type m;
      m.r00 = 16'(a00);
      m.r10 = 16'(a10);
      m.r11 = 16'(a11);
      m.r12 = 16'(a12);
      m.r20 = 16'(a20);
      m.r21 = 16'(a21);
      m.r22 = 16'(a22);
      return m;
   endfunction

   function automatic int to_q214(real v);
      int q;
      q = $rtoi(v * 16384.0 + ((v >= 0.0) ? 0.5 : -0.5));
      if (q > 16384)
         q = 16384;
      if (q < -16384)
         q = -16384;
      return q;
   endfunction

   // Matrix of Rz(yaw) * Ry(pitch) * Rx(roll) in Q2.14.
   function automatic mat_type rotation(real roll, real pitch, real yaw);
      real sr, cr, sp, cp, sz, cz;
      sr = $sin(roll);
      cr = $cos(roll);
      sp = $sin(pitch);
      cp = $cos(pitch);
      sz = $sin(yaw);
      cz = $cos(yaw);
      return matrix_of(to_q214(cz * cp), to_q214(sz * cp), to_q214(sz * sp * sr + cz * cr),
                       to_q214(sz * sp * cr - cz * sr), to_q214(-sp), to_q214(cp * sr),
                       to_q214(cp * cr));
   endfunction

   function automatic real any_angle();
      return (real'($urandom_range(62832)) - 31416.0) / 10000.0;
   endfunction

   // Mostly proper rotations, some close to gimbal lock, the rest raw noise.
   function automatic mat_type random_matrix();
      int  pick;
      real tilt;
      pick = $urandom_range(99);
      if (pick < 55)
         return rotation(any_angle(), any_angle() / 2.0, any_angle());
      if (pick < 75) begin
         tilt = PI_R / 2.0 - real'($urandom_range(2000)) / 100000.0;
         if ($urandom_range(1) == 1)
            tilt = -tilt;
         return rotation(any_angle(), tilt, any_angle());
      end
      if (pick < 90)
         return matrix_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom);
      return matrix_of(int'($urandom_range(16)) - 8, int'($urandom_range(16)) - 8,
                       int'($urandom_range(16)) - 8, int'($urandom_range(16)) - 8,
                       int'($urandom_range(16)) - 8, int'($urandom_range(16)) - 8,
                       int'($urandom_range(16)) - 8);
   endfunction

   // Offers one matrix beat, after an optional random gap, until accepted.
   task automatic send_matrix(input mat_type m);
      if (!steady && $urandom_range(99) < CHAN_STALL) begin
         req_tvalid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(99) < CHAN_STALL);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {m.r22, m.r21, m.r20, m.r12, m.r11, m.r10, m.r00};
      do
         @(posedge clock);
      while (!req_tready);
      chk.note_matrix(m);
   endtask

   // Holds the source back until every expected result has come out.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (chk.outstanding() != 0)
         @(posedge clock);
   endtask

   // Reprograms the singularity limit; the pipeline is empty here.
   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      wait_for_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      chk.set_limit(value);
   endtask

   task automatic random_batch(input int count, input int pause_at);
      for (int k = 0; k < count; k++) begin
         if (k == pause_at)
            wait_for_results();
         send_matrix(random_matrix());
      end
   endtask

   // Overall time limit.
   initial begin
      #400000;
      $display("status: fail");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed beats under the reset limit of one.
      send_matrix(matrix_of(16384, 0, 16384, 0, 0, 0, 16384));
      send_matrix(matrix_of(0, 0, 0, 0, 0, 0, 0));
      send_matrix(matrix_of(1, 0, 0, 0, 0, 0, 0));
      send_matrix(matrix_of(16384, 16384, 16384, 16384, 16384, 16384, 16384));
      send_matrix(matrix_of(-16384, -16384, -16384, -16384, -16384, -16384, -16384));
      send_matrix(matrix_of(32767, 32767, 32767, 32767, 32767, 32767, 32767));
      send_matrix(matrix_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
      send_matrix(matrix_of(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
                            16'h5555));
      send_matrix(matrix_of(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
                            16'haaaa));
      // Gimbal lock at both poles, and a singular case with a zero roll vector.
      send_matrix(rotation(PI_R / 6.0, PI_R / 2.0, 0.3));
      send_matrix(rotation(-PI_R / 3.0, -PI_R / 2.0, -1.1));
      send_matrix(matrix_of(0, 0, 0, 0, 16384, 0, 0));
      // Negative x with positive and negative y, and x of zero.
      send_matrix(matrix_of(-16000, 100, 0, 0, 0, 100, -16000));
      send_matrix(matrix_of(-16000, -100, 0, 0, 0, -100, -16000));
      send_matrix(matrix_of(-16384, 0, 0, 0, 0, 0, -16384));
      send_matrix(matrix_of(0, 16384, 0, 0, 0, -16384, 0));
      send_matrix(matrix_of(0, -16384, 0, 0, 0, 16384, 0));
      // Quarter turns about each axis.
      send_matrix(rotation(PI_R / 2.0, 0.0, 0.0));
      send_matrix(rotation(0.0, PI_R / 2.0 - 0.001, 0.0));
      send_matrix(rotation(0.0, 0.0, -PI_R / 2.0));

      // Highest nominal limit: sy just below and at the limit.
      write_limit(LIMIT_W'(16384));
      send_matrix(matrix_of(16383, 0, 100, 200, 300, 400, 500));
      send_matrix(matrix_of(16384, 0, 100, 200, 300, 400, 500));
      send_matrix(matrix_of(0, -16384, -100, -200, -300, -400, -500));
      random_batch(100, 50);

      // Never singular.
      write_limit('0);
      send_matrix(matrix_of(0, 0, 1000, 2000, 16384, 3000, 4000));
      random_batch(100, -1);

      // Back-to-back stretch with no idling on either side.
      write_limit(LIMIT_W'(700));
      steady <= 1'b1;
      random_batch(150, -1);
      steady <= 1'b0;

      // Largest register value: entries just below full scale can still be singular.
      write_limit(LIMIT_W'(32767));
      send_matrix(matrix_of(32766, 0, 1, 2, 3, 4, 5));
      send_matrix(matrix_of(-32768, -32768, 1, 2, 3, 4, 5));
      random_batch(80, 40);

      write_limit(LIMIT_W'($urandom_range(1, 2000)));
      random_batch(100, -1);

      write_limit(LIMIT_W'(1));
      random_batch(100, -1);

      // Drain and let the pipeline settle before the verdict.
      wait_for_results();
      repeat (SETTLE_CYC) @(posedge clock);
      if (chk.failures() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
